// ===== rtl/timer_task_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Timer task table assertion macros
// Clocked assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TIMER_TASK_TABLE_CORE_DEFINES_SVH
`define TIMER_TASK_TABLE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TTT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("timer task table assertion failed");
`define TTT_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("timer task table forbidden condition");
`else
`define TTT_ASSERT(lbl, clk, rst, prop)
`define TTT_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== rtl/ttt_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer task table package
// Table geometry, entry layout, command and result codes.
// ----------------------------------------------------------------------------
package ttt_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int SLOT_W     = $clog2(TASK_SLOTS);
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
   localparam int NOW_W      = 48;
   localparam int DUE_W      = 49;
   localparam int MS_W       = 32;
   localparam int HANDLE_W   = 8;

   localparam logic [1:0] CMD_SCHEDULE     = 2'd0;
   localparam logic [1:0] CMD_CANCEL_TIMER = 2'd1;
   localparam logic [1:0] CMD_CANCEL_TASK  = 2'd2;
   localparam logic [1:0] CMD_TICK         = 2'd3;

   localparam logic [2:0] KIND_FIRED     = 3'd0;
   localparam logic [2:0] KIND_TICK_DONE = 3'd1;
   localparam logic [2:0] KIND_SCHEDULED = 3'd2;
   localparam logic [2:0] KIND_REJECTED  = 3'd3;
   localparam logic [2:0] KIND_CANCELED  = 3'd4;

   typedef struct packed {
      logic [HANDLE_W-1:0] timer_id;
      logic [HANDLE_W-1:0] task_id;
      logic [DUE_W-1:0]    due;
      logic [MS_W-1:0]     period;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         data;
   } slot_write_type;

endpackage

// ===== rtl/timer_task_table_core.sv =====
// ----------------------------------------------------------------------------
// Timer task table core
// Schedules, cancels and fires timer tasks kept in insertion order.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A schedule with a
// null timer or task handle is dropped in that cycle and gives no result.
// Every other request walks the table one slot per cycle, closing up freed
// slots as it goes, notices the end of the table and then passes through a
// finishing state before busy falls again.
// Results appear on the rsp_ ports for a single cycle under rsp_valid and
// cannot be held off by the receiver; a tick gives one result per due slot in
// table order and closes with a tick done result that carries rsp_last.
// ----------------------------------------------------------------------------
`include "timer_task_table_core_defines.svh"

module timer_task_table_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_command,
   input  logic [ttt_pkg::HANDLE_W-1:0]     req_timer_id,
   input  logic [ttt_pkg::HANDLE_W-1:0]     req_task_id,
   input  logic [ttt_pkg::MS_W-1:0]         req_delay_ms,
   input  logic [ttt_pkg::MS_W-1:0]         req_period_ms,
   input  logic [ttt_pkg::NOW_W-1:0]        req_now_ms,
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_result_kind,
   output logic [ttt_pkg::HANDLE_W-1:0]     rsp_fired_task,
   output logic [ttt_pkg::HANDLE_W-1:0]     rsp_fired_timer,
   output logic                             rsp_found,
   output logic                             rsp_last
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [1:0]                    cmd_ff, cmd_in;
   logic [ttt_pkg::HANDLE_W-1:0]  timer_ff, timer_in;
   logic [ttt_pkg::HANDLE_W-1:0]  task_ff, task_in;
   logic [ttt_pkg::MS_W-1:0]      delay_ff, delay_in;
   logic [ttt_pkg::MS_W-1:0]      period_ff, period_in;
   logic [ttt_pkg::NOW_W-1:0]     now_ff, now_in;
   logic [ttt_pkg::CNT_W-1:0]     used_ff, used_in;
   logic [ttt_pkg::CNT_W-1:0]     rd_ff, rd_in;
   logic [ttt_pkg::CNT_W-1:0]     wr_ff, wr_in;
   logic                          any_ff, any_in;

   logic                          valid_ff, valid_in;
   logic [2:0]                    kind_ff, kind_in;
   logic [ttt_pkg::HANDLE_W-1:0]  otask_ff, otask_in;
   logic [ttt_pkg::HANDLE_W-1:0]  otimer_ff, otimer_in;
   logic                          found_ff, found_in;
   logic                          last_ff, last_in;

   ttt_pkg::slot_write_type       wr_port;
   ttt_pkg::entry_type            ent;
   logic [ttt_pkg::MS_W-1:0]      addend;
   logic [ttt_pkg::DUE_W-1:0]     sum;
   logic                          due_hit;
   logic                          drop;
   logic                          accept;

   ttt_slot_table u_slots (
      .clock   (clock),
      .wr      (wr_port),
      .rd_addr (rd_in[ttt_pkg::SLOT_W-1:0]),
      .rd_data (ent)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Shared adder: entry period during the walk, request delay when finishing.
   assign addend  = (state_ff == ST_FINISH) ? delay_ff : ent.period;
   assign sum     = {1'b0, now_ff} + {{(ttt_pkg::DUE_W - ttt_pkg::MS_W){1'b0}}, addend};
   assign due_hit = (ent.due <= {1'b0, now_ff});

   always_comb begin
      unique case (cmd_ff)
         ttt_pkg::CMD_SCHEDULE:     drop = (ent.timer_id == timer_ff) &&
                                           (ent.task_id == task_ff);
         ttt_pkg::CMD_CANCEL_TIMER: drop = (ent.timer_id == timer_ff);
         ttt_pkg::CMD_CANCEL_TASK:  drop = (ent.task_id == task_ff);
         ttt_pkg::CMD_TICK:         drop = due_hit && (ent.period == '0);
         default:                   drop = 1'b0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      timer_in  = timer_ff;
      task_in   = task_ff;
      delay_in  = delay_ff;
      period_in = period_ff;
      now_in    = now_ff;
      used_in   = used_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      any_in    = any_ff;
      valid_in  = 1'b0;
      kind_in   = kind_ff;
      otask_in  = otask_ff;
      otimer_in = otimer_ff;
      found_in  = found_ff;
      last_in   = last_ff;
      wr_port   = '{en: 1'b0, addr: wr_ff[ttt_pkg::SLOT_W-1:0], data: ent};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_command;
               timer_in  = req_timer_id;
               task_in   = req_task_id;
               delay_in  = req_delay_ms;
               period_in = req_period_ms;
               now_in    = req_now_ms;
               rd_in     = '0;
               wr_in     = '0;
               any_in    = 1'b0;
               if (!(req_command == ttt_pkg::CMD_SCHEDULE &&
                     (req_timer_id == '0 || req_task_id == '0))) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_ff == used_ff) begin
               state_in = ST_FINISH;
            end else begin
               rd_in = rd_ff + ttt_pkg::CNT_W'(1);
               if (drop) begin
                  any_in = 1'b1;
               end else begin
                  wr_port.en = 1'b1;
                  if (cmd_ff == ttt_pkg::CMD_TICK && due_hit) begin
                     wr_port.data.due = sum;
                  end
                  wr_in = wr_ff + ttt_pkg::CNT_W'(1);
               end
               if (cmd_ff == ttt_pkg::CMD_TICK && due_hit) begin
                  valid_in  = 1'b1;
                  kind_in   = ttt_pkg::KIND_FIRED;
                  otask_in  = ent.task_id;
                  otimer_in = ent.timer_id;
                  found_in  = 1'b0;
                  last_in   = 1'b0;
               end
            end
         end
         ST_FINISH: begin
            state_in  = ST_IDLE;
            used_in   = wr_ff;
            valid_in  = 1'b1;
            otask_in  = '0;
            otimer_in = '0;
            found_in  = 1'b0;
            last_in   = 1'b1;
            unique case (cmd_ff)
               ttt_pkg::CMD_SCHEDULE: begin
                  if (wr_ff == ttt_pkg::CNT_W'(ttt_pkg::TASK_SLOTS)) begin
                     kind_in = ttt_pkg::KIND_REJECTED;
                  end else begin
                     kind_in    = ttt_pkg::KIND_SCHEDULED;
                     wr_port.en = 1'b1;
                     wr_port.data = '{timer_id: timer_ff, task_id: task_ff,
                                      due: sum, period: period_ff};
                     used_in = wr_ff + ttt_pkg::CNT_W'(1);
                  end
               end
               ttt_pkg::CMD_CANCEL_TIMER: kind_in = ttt_pkg::KIND_CANCELED;
               ttt_pkg::CMD_CANCEL_TASK: begin
                  kind_in  = ttt_pkg::KIND_CANCELED;
                  found_in = any_ff;
               end
               ttt_pkg::CMD_TICK:         kind_in = ttt_pkg::KIND_TICK_DONE;
               default:                   kind_in = ttt_pkg::KIND_TICK_DONE;
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      timer_ff  <= timer_in;
      task_ff   <= task_in;
      delay_ff  <= delay_in;
      period_ff <= period_in;
      now_ff    <= now_in;
      rd_ff     <= rd_in;
      wr_ff     <= wr_in;
      any_ff    <= any_in;
      kind_ff   <= kind_in;
      otask_ff  <= otask_in;
      otimer_ff <= otimer_in;
      found_ff  <= found_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_fired_task  = otask_ff;
   assign rsp_fired_timer = otimer_ff;
   assign rsp_found       = found_ff;
   assign rsp_last        = last_ff;

   `TTT_ASSERT_NEVER(a_used_in_range, clock, reset,
      used_ff > ttt_pkg::CNT_W'(ttt_pkg::TASK_SLOTS))
   `TTT_ASSERT(a_write_behind_read, clock, reset,
      (state_ff == ST_SCAN) |-> (wr_ff <= rd_ff && rd_ff <= used_ff))
   `TTT_ASSERT_NEVER(a_fired_not_last, clock, reset,
      rsp_valid && rsp_result_kind == ttt_pkg::KIND_FIRED && rsp_last)
   `TTT_ASSERT(a_non_schedule_starts, clock, reset,
      (accept && req_command != ttt_pkg::CMD_SCHEDULE) |=> busy)
   `TTT_ASSERT(a_last_frees_block, clock, reset,
      (rsp_valid && rsp_last) |-> !busy)

endmodule

// ===== rtl/ttt_slot_table.sv =====
// ----------------------------------------------------------------------------
// Timer task table slot storage
// Register file of task entries with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module ttt_slot_table (
   input  logic                           clock,
   input  ttt_pkg::slot_write_type        wr,
   input  logic [ttt_pkg::SLOT_W-1:0]     rd_addr,
   output ttt_pkg::entry_type             rd_data
);

   ttt_pkg::entry_type slot_ff [ttt_pkg::TASK_SLOTS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= slot_ff[rd_addr];
   end

endmodule

// ===== tb/timer_task_table_check.sv =====
// ----------------------------------------------------------------------------
// Timer task table request and result checker
// Watches the request and result channels of the timer task table, keeps its
// own copy of the table, works out the results each accepted request must
// give and compares every result with the oldest one still owed.
// ----------------------------------------------------------------------------
module timer_task_table_check
   import ttt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [1:0]          req_command,
   input  logic [HANDLE_W-1:0] req_timer_id,
   input  logic [HANDLE_W-1:0] req_task_id,
   input  logic [MS_W-1:0]     req_delay_ms,
   input  logic [MS_W-1:0]     req_period_ms,
   input  logic [NOW_W-1:0]    req_now_ms,
   input  logic                rsp_valid,
   input  logic [2:0]          rsp_result_kind,
   input  logic [HANDLE_W-1:0] rsp_fired_task,
   input  logic [HANDLE_W-1:0] rsp_fired_timer,
   input  logic                rsp_found,
   input  logic                rsp_last,
   output int                  mismatches,
   output int                  outstanding
);

   typedef struct packed {
      logic [2:0]          kind;
      logic [HANDLE_W-1:0] task_h;
      logic [HANDLE_W-1:0] timer_h;
      logic                found;
      logic                last;
   } table_event_type;

   logic [HANDLE_W-1:0] slot_timer  [TASK_SLOTS];
   logic [HANDLE_W-1:0] slot_task   [TASK_SLOTS];
   logic [DUE_W-1:0]    slot_due    [TASK_SLOTS];
   logic [MS_W-1:0]     slot_period [TASK_SLOTS];
   int                  slots_used = 0;
   table_event_type     owed_events [$];
   table_event_type     got_event;
   table_event_type     want_event;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic string describe(input table_event_type ev);
      return $sformatf("kind=%0d task=%0d timer=%0d found=%0b last=%0b",
                       ev.kind, ev.task_h, ev.timer_h, ev.found, ev.last);
   endfunction

   function automatic void owe(input logic [2:0] kind, input logic [HANDLE_W-1:0] task_h,
                               input logic [HANDLE_W-1:0] timer_h, input logic found,
                               input logic last);
      table_event_type ev;
      ev = {kind, task_h, timer_h, found, last};
      owed_events.insert(owed_events.size(), ev);
   endfunction

   // Freed slots are squeezed out; the survivors keep their order.
   function automatic void close_gaps(input logic [TASK_SLOTS-1:0] drop);
      int keep;
      keep = 0;
      for (int r = 0; r < slots_used; r++) begin
         if (!drop[r]) begin
            slot_timer[keep]  = slot_timer[r];
            slot_task[keep]   = slot_task[r];
            slot_due[keep]    = slot_due[r];
            slot_period[keep] = slot_period[r];
            keep++;
         end
      end
      slots_used = keep;
   endfunction

   function automatic void apply_table_request(
      input logic [1:0]          cmd,
      input logic [HANDLE_W-1:0] timer_h,
      input logic [HANDLE_W-1:0] task_h,
      input logic [MS_W-1:0]     delay,
      input logic [MS_W-1:0]     period,
      input logic [NOW_W-1:0]    now);
      logic [TASK_SLOTS-1:0] drop;
      logic                  any_hit;
      drop    = '0;
      any_hit = 1'b0;
      case (cmd)
         CMD_SCHEDULE: begin
            if (timer_h != '0 && task_h != '0) begin
               for (int i = 0; i < slots_used; i++)
                  drop[i] = (slot_timer[i] == timer_h) && (slot_task[i] == task_h);
               close_gaps(drop);
               if (slots_used >= TASK_SLOTS) begin
                  owe(KIND_REJECTED, '0, '0, 1'b0, 1'b1);
               end else begin
                  slot_timer[slots_used]  = timer_h;
                  slot_task[slots_used]   = task_h;
                  slot_due[slots_used]    = now + delay;
                  slot_period[slots_used] = period;
                  slots_used++;
                  owe(KIND_SCHEDULED, '0, '0, 1'b0, 1'b1);
               end
            end
         end
         CMD_CANCEL_TIMER, CMD_CANCEL_TASK: begin
            for (int i = 0; i < slots_used; i++) begin
               drop[i] = (cmd == CMD_CANCEL_TIMER) ? (slot_timer[i] == timer_h)
                                                   : (slot_task[i] == task_h);
               any_hit = any_hit | drop[i];
            end
            close_gaps(drop);
            owe(KIND_CANCELED, '0, '0, (cmd == CMD_CANCEL_TASK) && any_hit, 1'b1);
         end
         default: begin
            for (int i = 0; i < slots_used; i++) begin
               if (slot_due[i] <= now) begin
                  owe(KIND_FIRED, slot_task[i], slot_timer[i], 1'b0, 1'b0);
                  if (slot_period[i] != '0)
                     slot_due[i] = now + slot_period[i];
                  else
                     drop[i] = 1'b1;
               end
            end
            close_gaps(drop);
            owe(KIND_TICK_DONE, '0, '0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         slots_used = 0;
         owed_events.delete();
      end else begin
         if (start && !busy)
            apply_table_request(req_command, req_timer_id, req_task_id, req_delay_ms,
                                req_period_ms, req_now_ms);
         if (rsp_valid) begin
            got_event = {rsp_result_kind, rsp_fired_task, rsp_fired_timer, rsp_found,
                         rsp_last};
            if (owed_events.size() == 0) begin
               report_mismatch({"result with none owed: ", describe(got_event)});
            end else begin
               want_event = owed_events.pop_front();
               if (got_event != want_event)
                  report_mismatch({"expected ", describe(want_event), ", got ",
                                   describe(got_event)});
            end
         end
      end
      outstanding = owed_events.size();
   end

endmodule

// ===== tb/timer_task_table_core_test.sv =====
// ----------------------------------------------------------------------------
// Timer task table core testbench
// Drives directed and random schedule, cancel and tick requests into the
// timer task table with random sender gaps, while a checker beside the block
// predicts and compares every result. Ends with a verdict once all owed
// results have arrived, or on a stall.
// ----------------------------------------------------------------------------
module timer_task_table_core_test;
   import ttt_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic [1:0]          req_command   = CMD_TICK;
   logic [HANDLE_W-1:0] req_timer_id  = '0;
   logic [HANDLE_W-1:0] req_task_id   = '0;
   logic [MS_W-1:0]     req_delay_ms  = '0;
   logic [MS_W-1:0]     req_period_ms = '0;
   logic [NOW_W-1:0]    req_now_ms    = '0;
   logic                busy;
   logic                rsp_valid;
   logic [2:0]          rsp_result_kind;
   logic [HANDLE_W-1:0] rsp_fired_task;
   logic [HANDLE_W-1:0] rsp_fired_timer;
   logic                rsp_found;
   logic                rsp_last;
   int                  mismatches;
   int                  outstanding;
   int                  idle_cycles = 0;
   logic                sender_idles = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   timer_task_table_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_timer_id    (req_timer_id),
      .req_task_id     (req_task_id),
      .req_delay_ms    (req_delay_ms),
      .req_period_ms   (req_period_ms),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_fired_task  (rsp_fired_task),
      .rsp_fired_timer (rsp_fired_timer),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last)
   );

   timer_task_table_check u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_timer_id    (req_timer_id),
      .req_task_id     (req_task_id),
      .req_delay_ms    (req_delay_ms),
      .req_period_ms   (req_period_ms),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_fired_task  (rsp_fired_task),
      .rsp_fired_timer (rsp_fired_timer),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Called right after a rising edge; returns right after the accepting edge.
   task automatic issue_command(input logic [1:0] cmd, input logic [HANDLE_W-1:0] timer_h,
                                input logic [HANDLE_W-1:0] task_h,
                                input logic [MS_W-1:0] delay, input logic [MS_W-1:0] period,
                                input logic [NOW_W-1:0] now);
      int   gap;
      logic was_busy;
      gap = 0;
      if (sender_idles)
         while ($urandom_range(0, 99) < 12)
            gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_command   <= cmd;
      req_timer_id  <= timer_h;
      req_task_id   <= task_h;
      req_delay_ms  <= delay;
      req_period_ms <= period;
      req_now_ms    <= now;
      forever begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
         if (!was_busy)
            break;
      end
   endtask

   task automatic wait_table_quiet();
      start <= 1'b0;
      do
         @(negedge clock);
      while (outstanding != 0 || busy);
      @(posedge clock);
   endtask

   function automatic logic [HANDLE_W-1:0] pick_timer();
      return ($urandom_range(0, 9) == 0) ? HANDLE_W'($urandom_range(0, 255))
                                         : HANDLE_W'($urandom_range(1, 4));
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_task();
      return ($urandom_range(0, 9) == 0) ? HANDLE_W'($urandom_range(0, 255))
                                         : HANDLE_W'($urandom_range(1, 8));
   endfunction

   initial begin
      logic [1:0]          cmd;
      logic [HANDLE_W-1:0] timer_h;
      logic [HANDLE_W-1:0] task_h;
      logic [MS_W-1:0]     delay;
      logic [MS_W-1:0]     period;
      logic [NOW_W-1:0]    now;
      logic [NOW_W-1:0]    base_ms;
      logic [NOW_W-1:0]    step_back;
      int                  sent;
      int                  pick;
      int                  burst_left;
      int                  bursts;
      int                  quiet_pauses;
      logic                ignored;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty tick, null handles, a full table, replacement,
      // cancels with and without a match, and ticks at both ends of time.
      issue_command(CMD_TICK, 8'd0, 8'd0, 32'd0, 32'd0, 48'd0);
      issue_command(CMD_SCHEDULE, 8'd0, 8'd5, 32'd1, 32'd1, 48'd0);
      issue_command(CMD_SCHEDULE, 8'd5, 8'd0, 32'd1, 32'd1, 48'd0);
      for (int i = 0; i < TASK_SLOTS; i++)
         issue_command(CMD_SCHEDULE,
                       (i == TASK_SLOTS - 1) ? 8'hFF : HANDLE_W'(1 + i % 3),
                       (i == TASK_SLOTS - 1) ? 8'hFF : HANDLE_W'(i + 1),
                       (i == 3) ? 32'hFFFF_FFFF : MS_W'(i * 10),
                       (i == 5) ? 32'hFFFF_FFFF : ((i % 2 == 1) ? 32'd5 : 32'd0),
                       48'd100);
      issue_command(CMD_SCHEDULE, 8'd9, 8'd9, 32'd1, 32'd0, 48'd100);
      issue_command(CMD_SCHEDULE, 8'd1, 8'd1, 32'd7, 32'd3, 48'd100);
      issue_command(CMD_TICK, 8'd0, 8'd0, 32'd0, 32'd0, 48'd150);
      issue_command(CMD_CANCEL_TASK, 8'd0, 8'd2, 32'd0, 32'd0, 48'd150);
      issue_command(CMD_CANCEL_TASK, 8'd0, 8'd200, 32'd0, 32'd0, 48'd150);
      issue_command(CMD_CANCEL_TIMER, 8'd0, 8'd0, 32'd0, 32'd0, 48'd150);
      issue_command(CMD_TICK, 8'd0, 8'd0, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
      issue_command(CMD_CANCEL_TIMER, 8'd1, 8'd0, 32'd0, 32'd0, 48'd0);
      issue_command(CMD_CANCEL_TIMER, 8'd2, 8'd0, 32'd0, 32'd0, 48'd0);
      issue_command(CMD_CANCEL_TIMER, 8'd255, 8'd0, 32'd0, 32'd0, 48'd0);

      // Random part: a small handle pool so entries collide, slowly moving
      // time with the odd step back or wild jump, and two bursts of long
      // schedules that overflow the table.
      base_ms      = '0;
      sent         = 0;
      burst_left   = 0;
      bursts       = 0;
      quiet_pauses = 0;
      while (sent < 150) begin
         sender_idles = (sent < 60 || sent >= 110);
         if (quiet_pauses < 2 && sent >= (quiet_pauses == 0 ? 90 : 140)) begin
            wait_table_quiet();
            quiet_pauses++;
         end
         if (bursts < 2 && burst_left == 0 && sent >= (bursts == 0 ? 30 : 125)) begin
            burst_left = 18;
            bursts++;
         end
         timer_h = pick_timer();
         task_h  = pick_task();
         delay   = ($urandom_range(0, 99) < 85) ? MS_W'($urandom_range(0, 60)) : $urandom();
         pick    = $urandom_range(0, 99);
         period  = (pick < 40) ? '0 :
                   (pick < 85) ? MS_W'($urandom_range(1, 40)) : $urandom();
         pick    = $urandom_range(0, 99);
         if (pick < 3) begin
            now = NOW_W'({$urandom(), $urandom()});
         end else begin
            if (pick < 8) begin
               step_back = NOW_W'($urandom_range(0, 30));
               base_ms   = (base_ms > step_back) ? base_ms - step_back : '0;
            end else begin
               base_ms = base_ms + NOW_W'($urandom_range(0, 20));
            end
            now = base_ms;
         end
         ignored = 1'b0;
         pick    = $urandom_range(0, 99);
         if (burst_left > 0) begin
            cmd     = CMD_SCHEDULE;
            timer_h = HANDLE_W'($urandom_range(1, 4));
            task_h  = HANDLE_W'($urandom_range(1, 255));
            delay   = MS_W'($urandom_range(100000, 1000000));
            burst_left--;
         end else if (pick < 45) begin
            cmd = CMD_SCHEDULE;
            ignored = (timer_h == '0 || task_h == '0);
         end else if (pick < 75) begin
            cmd = CMD_TICK;
         end else if (pick < 85) begin
            cmd = CMD_CANCEL_TIMER;
         end else if (pick < 95) begin
            cmd = CMD_CANCEL_TASK;
         end else begin
            cmd = CMD_SCHEDULE;
            if ($urandom_range(0, 1) == 1)
               timer_h = '0;
            else
               task_h = '0;
            ignored = 1'b1;
         end
         issue_command(cmd, timer_h, task_h, delay, period, now);
         if (!ignored)
            sent++;
      end

      start <= 1'b0;
      do
         @(negedge clock);
      while (outstanding != 0 || busy);
      repeat (TASK_SLOTS + 8) @(negedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ttt_pkg.sv
rtl/ttt_slot_table.sv
rtl/timer_task_table_core.sv
tb/timer_task_table_check.sv
tb/timer_task_table_core_test.sv
